[hw/rtl/qts_pkg.sv]
`default_nettype none

package qts_pkg;

   // scan modes of the tokenizer
   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_PLAIN   = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   // configuration register indexes
   localparam logic CSR_DELIM_COUNT = 1'b0;
   localparam logic CSR_DELIM_BYTES = 1'b1;

   // register reset values: space, tab, CR, LF
   localparam logic [2:0]  DELIM_COUNT_RESET = 3'd4;
   localparam logic [31:0] DELIM_BYTES_RESET = 32'h0A0D_0920;
   localparam int unsigned DELIM_SLOTS       = 4;

   // character constants
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N     = 8'h6E;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // scanner state carried from byte to byte
   typedef struct packed {
      mode_type mode;
      logic     after_backslash;
      logic     backslash_odd;
      logic     attach_flag;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      mode:            MODE_BETWEEN,
      after_backslash: 1'b0,
      backslash_odd:   1'b0,
      attach_flag:     1'b1
   };

   // one result beat
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       token_done;
      logic       line_done;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/qts_step.sv]
`default_nettype none

module qts_step (
   input  wire logic [7:0]             line_byte,
   input  wire logic                   line_last,
   input  wire logic [2:0]             delim_count,
   input  wire logic [31:0]            delim_bytes,
   input  wire qts_pkg::scan_state_type state_cur,
   output qts_pkg::scan_state_type     state_nxt,
   output qts_pkg::result_type         result
);

   logic       is_delim;
   logic [2:0] used_count;
   logic [7:0] escaped;

   // delimiter match, count above four acts as four
   always_comb begin
      used_count = (delim_count > 3'(qts_pkg::DELIM_SLOTS)) ?
                   3'(qts_pkg::DELIM_SLOTS) : delim_count;
      is_delim = 1'b0;
      for (int i = 0; i < qts_pkg::DELIM_SLOTS; i++) begin
         if ((3'(i) < used_count) && (delim_bytes[8*i +: 8] == line_byte)) begin
            is_delim = 1'b1;
         end
      end
   end

   // escape decoding
   always_comb begin
      case (line_byte)
         qts_pkg::CHAR_N: escaped = qts_pkg::CHAR_LF;
         qts_pkg::CHAR_R: escaped = qts_pkg::CHAR_CR;
         qts_pkg::CHAR_T: escaped = qts_pkg::CHAR_TAB;
         default:         escaped = line_byte;
      endcase
   end

   // mode transitions and result
   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      case (state_cur.mode)
         qts_pkg::MODE_BETWEEN: begin
            if (!is_delim) begin
               if (line_byte == qts_pkg::CHAR_HASH) begin
                  state_nxt.mode = qts_pkg::MODE_COMMENT;
               end else if (line_byte == qts_pkg::CHAR_QUOTE) begin
                  state_nxt.mode            = qts_pkg::MODE_QUOTED;
                  state_nxt.after_backslash = 1'b0;
                  state_nxt.backslash_odd   = 1'b0;
               end else begin
                  state_nxt.mode    = qts_pkg::MODE_PLAIN;
                  result.byte_valid = 1'b1;
                  result.out_byte   = line_byte;
               end
            end
         end
         qts_pkg::MODE_PLAIN: begin
            if (is_delim) begin
               result.token_done = 1'b1;
               state_nxt.mode    = qts_pkg::MODE_BETWEEN;
            end else begin
               result.byte_valid = 1'b1;
               result.out_byte   = line_byte;
            end
         end
         qts_pkg::MODE_QUOTED: begin
            if ((line_byte == qts_pkg::CHAR_QUOTE) && !state_cur.backslash_odd) begin
               result.token_done         = 1'b1;
               state_nxt.mode            = qts_pkg::MODE_BETWEEN;
               state_nxt.after_backslash = 1'b0;
            end else if (line_byte == qts_pkg::CHAR_BSLASH) begin
               // second backslash of a pair follows the attach flag
               if (state_cur.after_backslash) begin
                  if (state_cur.attach_flag) begin
                     result.byte_valid = 1'b1;
                     result.out_byte   = qts_pkg::CHAR_BSLASH;
                  end
                  state_nxt.attach_flag = ~state_cur.attach_flag;
               end
               state_nxt.after_backslash = 1'b1;
               state_nxt.backslash_odd   = ~state_cur.backslash_odd;
            end else begin
               result.byte_valid         = 1'b1;
               result.out_byte           = state_cur.after_backslash ? escaped : line_byte;
               state_nxt.after_backslash = 1'b0;
               state_nxt.backslash_odd   = 1'b0;
            end
         end
         qts_pkg::MODE_COMMENT: begin
            state_nxt = state_cur;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase

      // line end closes any open token and restores the reset state
      if (line_last) begin
         if ((state_nxt.mode == qts_pkg::MODE_PLAIN) ||
             (state_nxt.mode == qts_pkg::MODE_QUOTED)) begin
            result.token_done = 1'b1;
         end
         state_nxt = qts_pkg::SCAN_STATE_RESET;
      end
      result.line_done = line_last;
   end

endmodule

`default_nettype wire

[hw/rtl/quoted_token_splitter_unit.sv]
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_line_byte, req_line_last
// rsp      out        rsp_valid/rsp_stall  rsp_byte_valid, rsp_out_byte,
//                                          rsp_token_done, rsp_line_done
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// one byte per cycle sustained while rsp is not stalled; a beat taken on req reaches rsp
// through the input register, then scanner logic into the result register
// reset is synchronous and restores delimiters and scanner state
// a stall on rsp while rsp_valid is high freezes both stages and is passed back to req in the same cycle

module quoted_token_splitter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_line_byte,
   input  wire logic        req_line_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_token_done,
   output logic             rsp_line_done,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   logic                    advance;
   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic                    out_valid_ff;
   qts_pkg::result_type     out_result_ff;
   qts_pkg::result_type     result_in;
   qts_pkg::scan_state_type state_ff;
   qts_pkg::scan_state_type state_in;
   logic [2:0]              delim_count_ff;
   logic [31:0]             delim_bytes_ff;

   // both stages move together unless the result is held
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_count_ff <= qts_pkg::DELIM_COUNT_RESET;
         delim_bytes_ff <= qts_pkg::DELIM_BYTES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            qts_pkg::CSR_DELIM_COUNT: delim_count_ff <= csr_write_data[2:0];
            qts_pkg::CSR_DELIM_BYTES: delim_bytes_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_line_byte;
         in_last_ff <= req_line_last;
      end
   end

   // scanner logic
   qts_step u_step (
      .line_byte   (in_byte_ff),
      .line_last   (in_last_ff),
      .delim_count (delim_count_ff),
      .delim_bytes (delim_bytes_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   // scanner state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qts_pkg::SCAN_STATE_RESET;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_valid = out_result_ff.byte_valid;
   assign rsp_out_byte   = out_result_ff.out_byte;
   assign rsp_token_done = out_result_ff.token_done;
   assign rsp_line_done  = out_result_ff.line_done;

endmodule

`default_nettype wire
